### hdl/quaternion_to_rotation_matrix_macros.svh
// ----------------------------------------------------------------------------
// quaternion_to_rotation_matrix_macros
// assertion macros used by the top-level rtl file
// ----------------------------------------------------------------------------
`ifndef QUATERNION_TO_ROTATION_MATRIX_MACROS_SVH
`define QUATERNION_TO_ROTATION_MATRIX_MACROS_SVH
`ifndef SYNTHESIS
`define QRM_ASSERT(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("qrm check failed");
`define QRM_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("qrm implication failed");
`else
`define QRM_ASSERT(lbl, cond)
`define QRM_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

### hdl/qrm_pkg.sv
// ----------------------------------------------------------------------------
// qrm_pkg
// types and constants of the quaternion to rotation matrix pipeline
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package qrm_pkg;
	localparam int IN_W      = 16;
	localparam int PROD_W    = 32;
	localparam int NUM_W     = 34;
	localparam int DEN_W     = 33;
	localparam int DIVD_W    = 48;
	localparam int FRAC_BITS = 14;
	localparam int DIV_STEPS = 15;
	localparam int N_ELEM    = 9;
	localparam int PIPE_LAT  = DIV_STEPS + 3;

	localparam logic [1:0] STS_NEAR = 2'd0;
	localparam logic [1:0] STS_FAR  = 2'd1;
	localparam logic [1:0] STS_ZERO = 2'd2;

	localparam logic [39:0] BAND_LO = 40'd81 << 28;
	localparam logic [39:0] BAND_HI = 40'd121 << 28;

	typedef struct packed {
		logic signed [IN_W-1:0] q_x;
		logic signed [IN_W-1:0] q_y;
		logic signed [IN_W-1:0] q_z;
		logic signed [IN_W-1:0] q_w;
	} quat_t;

	typedef struct packed {
		logic signed [15:0] m00;
		logic signed [15:0] m01;
		logic signed [15:0] m02;
		logic signed [15:0] m10;
		logic signed [15:0] m11;
		logic signed [15:0] m12;
		logic signed [15:0] m20;
		logic signed [15:0] m21;
		logic signed [15:0] m22;
		logic [1:0]         status;
	} dcm_t;

	typedef struct packed {
		logic signed [PROD_W-1:0] xx;
		logic signed [PROD_W-1:0] yy;
		logic signed [PROD_W-1:0] zz;
		logic signed [PROD_W-1:0] ww;
		logic signed [PROD_W-1:0] xy;
		logic signed [PROD_W-1:0] zw;
		logic signed [PROD_W-1:0] xz;
		logic signed [PROD_W-1:0] yw;
		logic signed [PROD_W-1:0] yz;
		logic signed [PROD_W-1:0] xw;
	} prod_t;

	typedef struct packed {
		logic [N_ELEM-1:0][DIVD_W-1:0] divd;
		logic [N_ELEM-1:0]             neg;
		logic [DEN_W-1:0]              den;
		logic [1:0]                    status;
	} numer_t;
endpackage
`default_nettype wire

### hdl/qrm_product.sv
// ----------------------------------------------------------------------------
// qrm_product
// first stage: the ten component products, registered
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module qrm_product import qrm_pkg::*; (
	input  wire logic  clk,
	input  wire quat_t q,
	output prod_t      prod_s1
);
	always_ff @(posedge clk) begin
		prod_s1.xx <= q.q_x * q.q_x;
		prod_s1.yy <= q.q_y * q.q_y;
		prod_s1.zz <= q.q_z * q.q_z;
		prod_s1.ww <= q.q_w * q.q_w;
		prod_s1.xy <= q.q_x * q.q_y;
		prod_s1.zw <= q.q_z * q.q_w;
		prod_s1.xz <= q.q_x * q.q_z;
		prod_s1.yw <= q.q_y * q.q_w;
		prod_s1.yz <= q.q_y * q.q_z;
		prod_s1.xw <= q.q_x * q.q_w;
	end
endmodule
`default_nettype wire

### hdl/qrm_numer.sv
// ----------------------------------------------------------------------------
// qrm_numer
// second stage: squared norm, numerators, dividends and band status
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module qrm_numer import qrm_pkg::*; (
	input  wire logic  clk,
	input  wire prod_t prod_s1,
	output numer_t     numer_s2
);
	logic signed [NUM_W-1:0] xx, yy, zz, ww, xy, zw, xz, yw, yz, xw;
	logic signed [NUM_W-1:0] num [N_ELEM];
	logic [DEN_W-1:0]        n2;
	logic [39:0]             scaled;
	numer_t                  nx;

	function automatic logic signed [NUM_W-1:0] sx(input logic signed [PROD_W-1:0] v);
		return {{(NUM_W-PROD_W){v[PROD_W-1]}}, v};
	endfunction

	assign xx = sx(prod_s1.xx);
	assign yy = sx(prod_s1.yy);
	assign zz = sx(prod_s1.zz);
	assign ww = sx(prod_s1.ww);
	assign xy = sx(prod_s1.xy);
	assign zw = sx(prod_s1.zw);
	assign xz = sx(prod_s1.xz);
	assign yw = sx(prod_s1.yw);
	assign yz = sx(prod_s1.yz);
	assign xw = sx(prod_s1.xw);

	// squares are non-negative, so the sum is exact in 33 bits
	assign n2 = DEN_W'(xx + yy + zz + ww);

	assign num[0] = xx - yy - zz + ww;
	assign num[1] = (xy + zw) <<< 1;
	assign num[2] = (xz - yw) <<< 1;
	assign num[3] = (xy - zw) <<< 1;
	assign num[4] = yy - xx - zz + ww;
	assign num[5] = (yz + xw) <<< 1;
	assign num[6] = (xz + yw) <<< 1;
	assign num[7] = (yz - xw) <<< 1;
	assign num[8] = zz - xx - yy + ww;

	// n2 * 100 as shifts and adds
	assign scaled = ({7'd0, n2} << 6) + ({7'd0, n2} << 5) + ({7'd0, n2} << 2);

	always_comb begin
		logic [DEN_W-1:0] mag;
		for (int i = 0; i < N_ELEM; i++) begin
			mag = num[i][NUM_W-1] ? DEN_W'(-num[i]) : DEN_W'(num[i]);
			nx.neg[i]  = num[i][NUM_W-1];
			nx.divd[i] = {mag, {FRAC_BITS{1'b0}}} + DIVD_W'(n2 >> 1);
		end
		nx.den = n2;
		if (n2 == '0)
			nx.status = STS_ZERO;
		else if (scaled < BAND_LO || scaled > BAND_HI)
			nx.status = STS_FAR;
		else
			nx.status = STS_NEAR;
	end

	always_ff @(posedge clk) begin
		numer_s2 <= nx;
	end
endmodule
`default_nettype wire

### hdl/qrm_div_lane.sv
// ----------------------------------------------------------------------------
// qrm_div_lane
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module qrm_div_lane import qrm_pkg::*; (
	input  wire logic              clk,
	input  wire logic [DIVD_W-1:0] divd,
	input  wire logic [DEN_W-1:0]  den,
	input  wire logic              neg,
	output logic signed [15:0]     res
);
	logic [DIVD_W-1:0]    rem_s [DIV_STEPS+1];
	logic [DEN_W-1:0]     den_s [DIV_STEPS+1];
	logic [DIV_STEPS-1:0] quo_s [DIV_STEPS+1];
	logic                 neg_s [DIV_STEPS+1];

	assign rem_s[0] = divd;
	assign den_s[0] = den;
	assign quo_s[0] = '0;
	assign neg_s[0] = neg;

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
		logic [DIVD_W-1:0] trial;
		logic              ge;
		assign trial = {{(DIVD_W-DEN_W){1'b0}}, den_s[k]} << (DIV_STEPS-1-k);
		assign ge    = rem_s[k] >= trial;
		always_ff @(posedge clk) begin
			rem_s[k+1] <= ge ? rem_s[k] - trial : rem_s[k];
			quo_s[k+1] <= {quo_s[k][DIV_STEPS-2:0], ge};
			den_s[k+1] <= den_s[k];
			neg_s[k+1] <= neg_s[k];
		end
	end

	assign res = neg_s[DIV_STEPS] ? -16'({1'b0, quo_s[DIV_STEPS]})
	                              : 16'({1'b0, quo_s[DIV_STEPS]});
endmodule
`default_nettype wire

### hdl/quaternion_to_rotation_matrix.sv
// ----------------------------------------------------------------------------
// quaternion_to_rotation_matrix
// quaternion (q_x, q_y, q_z, q_w in q1.14) to 3x3 direction cosine matrix
// ----------------------------------------------------------------------------
// takes one word per clock whenever start is high (busy stays low, so the
// block never pushes back) and gives each matrix word with done high for
// one cycle; the receiver cannot stall, so words must be taken as they
// come. the pipeline is the product stage, the numerator stage, the
// 15-stage bit-per-stage divider that scales every element by the squared
// norm, and the output register. elements are rounded to nearest (ties
// away from zero) in q1.14; status flags a norm outside 0.9..1.1 and a
// zero quaternion, which yields a zero matrix.
`timescale 1ns / 1ps
`default_nettype none
`include "quaternion_to_rotation_matrix_macros.svh"
module quaternion_to_rotation_matrix import qrm_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  start,
	output logic       busy,
	input  wire quat_t q,
	output logic       done,
	output dcm_t       m
);
	prod_t             prod_s1;
	numer_t            numer_s2;
	logic              vld_s1, vld_s2;
	logic              vld_d_s [DIV_STEPS];
	logic [1:0]        sts_d_s [DIV_STEPS];
	logic signed [15:0] res [N_ELEM];
	logic              done_q;
	dcm_t              m_q;

	// never stalls: a new word can enter every cycle
	assign busy = 1'b0;

	// stage 1: products
	qrm_product u_product (
		.clk     (clk),
		.q       (q),
		.prod_s1 (prod_s1)
	);

	// stage 2: norm, numerators, status
	qrm_numer u_numer (
		.clk      (clk),
		.prod_s1  (prod_s1),
		.numer_s2 (numer_s2)
	);

	// one divider lane per matrix element
	for (genvar i = 0; i < N_ELEM; i++) begin : g_lane
		qrm_div_lane u_lane (
			.clk  (clk),
			.divd (numer_s2.divd[i]),
			.den  (numer_s2.den),
			.neg  (numer_s2.neg[i]),
			.res  (res[i])
		);
	end

	// valid bits follow the data through every stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			for (int k = 0; k < DIV_STEPS; k++) vld_d_s[k] <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1     <= start && !busy;
			vld_s2     <= vld_s1;
			vld_d_s[0] <= vld_s2;
			for (int k = 1; k < DIV_STEPS; k++) vld_d_s[k] <= vld_d_s[k-1];
			done_q     <= vld_d_s[DIV_STEPS-1];
		end
	end

	// status rides alongside the divider
	always_ff @(posedge clk) begin
		sts_d_s[0] <= numer_s2.status;
		for (int k = 1; k < DIV_STEPS; k++) sts_d_s[k] <= sts_d_s[k-1];
	end

	// output register; a zero quaternion forces a zero matrix
	always_ff @(posedge clk) begin
		if (sts_d_s[DIV_STEPS-1] == STS_ZERO) begin
			m_q.m00 <= '0; m_q.m01 <= '0; m_q.m02 <= '0;
			m_q.m10 <= '0; m_q.m11 <= '0; m_q.m12 <= '0;
			m_q.m20 <= '0; m_q.m21 <= '0; m_q.m22 <= '0;
		end else begin
			m_q.m00 <= res[0]; m_q.m01 <= res[1]; m_q.m02 <= res[2];
			m_q.m10 <= res[3]; m_q.m11 <= res[4]; m_q.m12 <= res[5];
			m_q.m20 <= res[6]; m_q.m21 <= res[7]; m_q.m22 <= res[8];
		end
		m_q.status <= sts_d_s[DIV_STEPS-1];
	end

	assign done = done_q;
	assign m    = m_q;

	// a result word only appears for a word taken the pipeline depth earlier
	`QRM_ASSERT_IMP(a_done_src, done, $past(start, PIPE_LAT))
	// a zero quaternion always comes out flagged zero
	`QRM_ASSERT_IMP(a_zero_flag, done && $past(q == '0, PIPE_LAT), m.status == STS_ZERO)
	// status is never the unused code
	`QRM_ASSERT_IMP(a_sts_code, done, m.status == STS_NEAR || m.status == STS_FAR || m.status == STS_ZERO)
	// m00 stays within unit magnitude
	`QRM_ASSERT_IMP(a_m00_range, done, m.m00 <= 16'sd16384 && m.m00 >= -16'sd16384)
endmodule
`default_nettype wire
